>>> rtl/core/mcr_pkg.sv
// Shared types, register codes and message constants for the MIDI channel router.
package mcr_pkg;

	localparam int CFG_DATA_W  = 14;
	localparam int CFG_INDEX_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DEST_MASK   = 3'd0,
		CFG_CH_FIRST    = 3'd1,
		CFG_CH_LAST     = 3'd2,
		CFG_MSG_CLASS   = 3'd3,
		CFG_CC_WINDOW   = 3'd4,
		CFG_FIRST_SEL   = 3'd5,
		CFG_SECOND_SEL  = 3'd6,
		CFG_THRU_SEL    = 3'd7
	} cfg_reg_t;

	// Message type nibbles.
	localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
	localparam logic [3:0] TYPE_CC        = 4'hB;
	localparam logic [3:0] TYPE_PROGRAM   = 4'hC;
	localparam logic [3:0] TYPE_PRESSURE  = 4'hD;
	localparam logic [3:0] TYPE_PITCHBEND = 4'hE;

	// Message class codes.
	localparam logic [1:0] CLASS_CC_ONLY  = 2'd0;
	localparam logic [1:0] CLASS_CC_NOTES = 2'd1;

	// Output selector codes; anything above SEL_SAME is a fixed channel.
	localparam logic [4:0] SEL_OFF  = 5'd0;
	localparam logic [4:0] SEL_SAME = 5'd1;

	// Reset values of the configuration registers.
	localparam logic [3:0]  RST_DEST_MASK  = 4'd1;
	localparam logic [4:0]  RST_CH_FIRST   = 5'd1;
	localparam logic [4:0]  RST_CH_LAST    = 5'd0;
	localparam logic [1:0]  RST_MSG_CLASS  = 2'd0;
	localparam logic [13:0] RST_CC_WINDOW  = 14'd16256;
	localparam logic [4:0]  RST_FIRST_SEL  = 5'd3;
	localparam logic [4:0]  RST_SECOND_SEL = 5'd4;
	localparam logic [4:0]  RST_THRU_SEL   = 5'd0;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] data_one;
		logic [6:0] data_two;
	} mcr_in_t;

	typedef struct packed {
		logic [7:0] out_status_byte;
		logic [6:0] out_data_one;
		logic [6:0] out_data_two;
		logic       has_third_byte;
		logic [3:0] send_destinations;
		logic       last_copy;
	} mcr_out_t;

	typedef struct packed {
		logic [3:0]  destination_mask;
		logic [4:0]  in_channel_first;
		logic [4:0]  in_channel_last;
		logic [1:0]  message_class;
		logic [13:0] cc_window;
		logic [4:0]  first_output_select;
		logic [4:0]  second_output_select;
		logic [4:0]  thru_output_select;
	} mcr_cfg_t;

	// One routed message waiting for the back end: its copies' channels in order.
	typedef struct packed {
		logic [3:0]      msg_type;
		logic [6:0]      data_one;
		logic [6:0]      data_two;
		logic            three;
		logic [3:0]      dest;
		logic [1:0]      copies;
		logic [2:0][3:0] chans;
	} mcr_job_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} mcr_qstat_t;

endpackage

>>> rtl/core/mcr_front.sv
// Front end: filters each incoming message and builds its list of output channels.
module mcr_front import mcr_pkg::*; (
	input  mcr_cfg_t   cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  mcr_in_t    in_item,
	input  mcr_qstat_t qstat,
	output logic       push,
	output mcr_job_t   job
);

	logic [3:0] msg_type;
	logic [3:0] in_ch;
	logic [4:0] ch_num;
	logic [4:0] hi_raw;
	logic [4:0] ch_lo;
	logic [4:0] ch_hi;
	logic       ch_ok;
	logic       type_ok;
	logic [6:0] cc_a;
	logic [6:0] cc_b;
	logic [6:0] cc_lo;
	logic [6:0] cc_hi;
	logic       cc_ok;
	logic       pass;
	logic       three;
	logic [2:0] sel_on;
	logic [2:0][3:0] sel_ch;
	logic [2:0] keep;
	logic [1:0] copies;

	function automatic logic [3:0] pick_channel(input logic [4:0] sel, input logic [3:0] ch);
		logic [3:0] res;
		if (sel == SEL_SAME) begin
			res = ch;
		end else begin
			res = sel[3:0] - 4'd2;
		end
		return res;
	endfunction

	assign msg_type = in_item.status_byte[7:4];
	assign in_ch    = in_item.status_byte[3:0];
	assign ch_num   = {1'b0, in_ch} + 5'd1;

	always_comb begin
		hi_raw = (cfg.in_channel_last == 5'd0) ? cfg.in_channel_first : cfg.in_channel_last;
		if (cfg.in_channel_first > hi_raw) begin
			ch_lo = hi_raw;
			ch_hi = cfg.in_channel_first;
		end else begin
			ch_lo = cfg.in_channel_first;
			ch_hi = hi_raw;
		end
		ch_ok = (cfg.in_channel_first == 5'd0) || (ch_num >= ch_lo && ch_num <= ch_hi);
	end

	always_comb begin
		priority if (msg_type == TYPE_CC) begin
			type_ok = 1'b1;
		end else if (cfg.message_class == CLASS_CC_ONLY) begin
			type_ok = 1'b0;
		end else if (cfg.message_class == CLASS_CC_NOTES) begin
			type_ok = (msg_type == TYPE_NOTE_OFF) || (msg_type == TYPE_NOTE_ON);
		end else begin
			type_ok = (msg_type >= TYPE_NOTE_OFF) && (msg_type <= TYPE_PITCHBEND);
		end
	end

	always_comb begin
		cc_a = cfg.cc_window[6:0];
		cc_b = cfg.cc_window[13:7];
		cc_lo = (cc_a > cc_b) ? cc_b : cc_a;
		cc_hi = (cc_a > cc_b) ? cc_a : cc_b;
		cc_ok = (msg_type != TYPE_CC) ||
			(in_item.data_one >= cc_lo && in_item.data_one <= cc_hi);
	end

	assign pass  = (cfg.destination_mask != 4'd0) && ch_ok && type_ok && cc_ok;
	assign three = !((msg_type == TYPE_PROGRAM) || (msg_type == TYPE_PRESSURE));

	// Duplicate removal: a later copy is dropped when its channel matches a kept one.
	always_comb begin
		sel_on[0] = cfg.first_output_select  != SEL_OFF;
		sel_on[1] = cfg.second_output_select != SEL_OFF;
		sel_on[2] = cfg.thru_output_select   != SEL_OFF;
		sel_ch[0] = pick_channel(cfg.first_output_select,  in_ch);
		sel_ch[1] = pick_channel(cfg.second_output_select, in_ch);
		sel_ch[2] = pick_channel(cfg.thru_output_select,   in_ch);
		keep[0] = sel_on[0];
		keep[1] = sel_on[1] && !(keep[0] && sel_ch[1] == sel_ch[0]);
		keep[2] = sel_on[2] && !(keep[0] && sel_ch[2] == sel_ch[0])
			&& !(keep[1] && sel_ch[2] == sel_ch[1]);
		copies = {1'b0, keep[0]} + {1'b0, keep[1]} + {1'b0, keep[2]};
	end

	always_comb begin
		job.msg_type = msg_type;
		job.data_one = in_item.data_one;
		job.data_two = three ? in_item.data_two : 7'd0;
		job.three    = three;
		job.dest     = cfg.destination_mask;
		job.copies   = copies;
		job.chans[0] = keep[0] ? sel_ch[0] : (keep[1] ? sel_ch[1] : sel_ch[2]);
		job.chans[1] = (keep[0] && keep[1]) ? sel_ch[1] : sel_ch[2];
		job.chans[2] = sel_ch[2];
	end

	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready && pass && (copies != 2'd0);

endmodule

>>> rtl/core/mcr_queue.sv
// Short job queue between the front and back ends.
module mcr_queue import mcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mcr_job_t   push_job,
	input  logic       pop,
	output mcr_job_t   head_job,
	output mcr_qstat_t qstat
);

	mcr_job_t          store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] res;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			res = '0;
		end else begin
			res = p + QPTR_W'(1);
		end
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign head_job       = store_q[rd_ptr_q];
	assign qstat.full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.nonempty = (count_q != '0);

endmodule

>>> rtl/core/mcr_back.sv
// Back end: sends the copies of the head job through an output register, one per cycle unless out_ready stalls it.
module mcr_back import mcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mcr_job_t   head_job,
	input  mcr_qstat_t qstat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output mcr_out_t   out_item
);

	logic [1:0] copy_q;
	logic       out_valid_q;
	mcr_out_t   out_item_q;
	logic       load;
	logic       last;
	logic [3:0] chan;

	assign load = !out_valid_q || out_ready;
	assign last = (copy_q == head_job.copies - 2'd1);
	assign pop  = load && qstat.nonempty && last;
	assign chan = head_job.chans[copy_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= qstat.nonempty;
			if (qstat.nonempty) begin
				copy_q <= last ? 2'd0 : copy_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && qstat.nonempty) begin
			out_item_q.out_status_byte   <= {head_job.msg_type, chan};
			out_item_q.out_data_one      <= head_job.data_one;
			out_item_q.out_data_two      <= head_job.data_two;
			out_item_q.has_third_byte    <= head_job.three;
			out_item_q.send_destinations <= head_job.dest;
			out_item_q.last_copy         <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

>>> rtl/core/midi_channel_router.sv
// Top level of the MIDI channel router: configuration registers, front, queue and back end.
//
// Input channel (in_valid / in_ready / in_item) takes one MIDI channel message per item.
// The front end checks the channel range, message class and controller window against the
// configuration and works out the list of output channels with duplicates removed; a message
// that passes is placed in a two-entry job queue, and one that fails is simply consumed.
// The back end reads the head job and sends its copies, first output, second output, thru,
// on the output channel (out_valid / out_ready / out_item), one copy per cycle unless the
// receiver stalls, the final copy flagged by last_copy.
// An accepted item is written into the job queue, and the back end then loads its first
// copy into the output register, from which the receiver takes it.
// The single output register carries one copy at a time: an item has one to three copies,
// and new items keep entering while the queue has room.
// When the receiver stalls, the output register holds its copy, the queue fills and
// in_ready falls once both queue entries are taken.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data) and should only be
// used while the block is idle. Reset clears the queue and the output register and
// restores every configuration register to its default.
module midi_channel_router import mcr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mcr_in_t                in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mcr_out_t               out_item
);

	mcr_cfg_t   cfg_q;
	mcr_qstat_t qstat;
	mcr_job_t   push_job;
	mcr_job_t   head_job;
	logic       push;
	logic       pop;

	// Each write keeps only the bits its register holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.destination_mask     <= RST_DEST_MASK;
			cfg_q.in_channel_first     <= RST_CH_FIRST;
			cfg_q.in_channel_last      <= RST_CH_LAST;
			cfg_q.message_class        <= RST_MSG_CLASS;
			cfg_q.cc_window            <= RST_CC_WINDOW;
			cfg_q.first_output_select  <= RST_FIRST_SEL;
			cfg_q.second_output_select <= RST_SECOND_SEL;
			cfg_q.thru_output_select   <= RST_THRU_SEL;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_DEST_MASK:  cfg_q.destination_mask     <= cfg_data[3:0];
				CFG_CH_FIRST:   cfg_q.in_channel_first     <= cfg_data[4:0];
				CFG_CH_LAST:    cfg_q.in_channel_last      <= cfg_data[4:0];
				CFG_MSG_CLASS:  cfg_q.message_class        <= cfg_data[1:0];
				CFG_CC_WINDOW:  cfg_q.cc_window            <= cfg_data[13:0];
				CFG_FIRST_SEL:  cfg_q.first_output_select  <= cfg_data[4:0];
				CFG_SECOND_SEL: cfg_q.second_output_select <= cfg_data[4:0];
				CFG_THRU_SEL:   cfg_q.thru_output_select   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	mcr_front u_front (
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.qstat    (qstat),
		.push     (push),
		.job      (push_job)
	);

	mcr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.qstat    (qstat)
	);

	mcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// A copy is only ever produced with routing enabled.
	a_dest_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.send_destinations != 4'd0)
		else $error("copy sent with an empty destination mask");

	// Two-byte messages carry a cleared second data byte.
	a_two_byte_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.has_third_byte) |-> out_item.out_data_two == 7'd0)
		else $error("two-byte copy with a nonzero second data byte");

	// Only channel voice types reach the output.
	a_voice_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.out_status_byte[7] && out_item.out_status_byte[7:4] != 4'hF))
		else $error("copy with a non-channel status byte");

	// The front end never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("job pushed into a full queue");

endmodule

>>> sim/tb_top.sv
// Testbench for the MIDI channel router: directed and random messages checked against a predictor.
`timescale 1ns / 100ps

module tb_top import mcr_pkg::*; ();

	// The run is stopped as failed if it is still going after this many cycles.
	// The slowest correct run is under 500 messages with three copies each, a stall
	// on every copy and a gap before every message, which stays well inside this limit.
	localparam int unsigned CYCLE_LIMIT = 200000;

	// Cycles allowed after the last expected copy before the block counts as idle.
	// A filtered message leaves nothing in the block, so this is a wide margin.
	localparam int SETTLE_CYCLES = 8;

	// Random part: messages per setting and the number of settings.
	localparam int MESSAGES_PER_PHASE = 44;
	localparam int RANDOM_PHASES      = 10;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	mcr_in_t                in_item   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	mcr_out_t               out_item;

	// Copy of the register file as the block should hold it right now.
	mcr_cfg_t route_cfg;

	// Copies the block still owes, oldest first.
	mcr_out_t pending_copies[$];

	// While set, neither side inserts gaps or stalls.
	bit steady = 1'b0;

	int          error_count = 0;
	int unsigned cycle_count = 0;

	midi_channel_router dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a copy that never arrives ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The receiver stalls about a third of the cycles unless the steady stretch is on.
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 34);
	end

	// Works out the copies that one message causes under the current settings and
	// queues them. Returns how many copies there are.
	function automatic int route_message(input mcr_in_t msg);
		logic [3:0] kind;
		logic [3:0] in_ch;
		logic [3:0] ch;
		logic [4:0] lo;
		logic [4:0] hi;
		logic [4:0] swap5;
		logic [4:0] offset;
		logic [6:0] cc_lo;
		logic [6:0] cc_hi;
		logic [6:0] swap7;
		logic [4:0] sels[3];
		logic [3:0] used[3];
		mcr_out_t   copies[3];
		bit         three;
		bit         pass;
		bit         dup;
		int         n;

		kind  = msg.status_byte[7:4];
		in_ch = msg.status_byte[3:0];
		n     = 0;

		// A zero destination mask switches routing off.
		if (route_cfg.destination_mask == 4'd0)
			return 0;

		// Input channel range, 1-based; zero first bound accepts everything, zero last
		// bound means a single channel, and reversed bounds are swapped.
		lo = route_cfg.in_channel_first;
		hi = route_cfg.in_channel_last;
		if (lo != 5'd0) begin
			if (hi == 5'd0)
				hi = lo;
			if (lo > hi) begin
				swap5 = lo;
				lo    = hi;
				hi    = swap5;
			end
			if (({1'b0, in_ch} + 5'd1) < lo || ({1'b0, in_ch} + 5'd1) > hi)
				return 0;
		end

		// Message class; the unused codes behave as all channel messages.
		case (route_cfg.message_class)
			CLASS_CC_ONLY: begin
				pass = (kind == TYPE_CC);
			end
			CLASS_CC_NOTES: begin
				pass = (kind == TYPE_CC) || (kind == TYPE_NOTE_OFF) || (kind == TYPE_NOTE_ON);
			end
			default: begin
				pass = (kind >= TYPE_NOTE_OFF) && (kind <= TYPE_PITCHBEND);
			end
		endcase
		if (!pass)
			return 0;

		// Controller window, also swapped when reversed.
		if (kind == TYPE_CC) begin
			cc_lo = route_cfg.cc_window[6:0];
			cc_hi = route_cfg.cc_window[13:7];
			if (cc_lo > cc_hi) begin
				swap7 = cc_lo;
				cc_lo = cc_hi;
				cc_hi = swap7;
			end
			if (msg.data_one < cc_lo || msg.data_one > cc_hi)
				return 0;
		end

		three   = !((kind == TYPE_PROGRAM) || (kind == TYPE_PRESSURE));
		sels[0] = route_cfg.first_output_select;
		sels[1] = route_cfg.second_output_select;
		sels[2] = route_cfg.thru_output_select;

		// First output, second output, thru; a copy on a channel already used is dropped.
		for (int i = 0; i < 3; i++) begin
			if (sels[i] != SEL_OFF) begin
				if (sels[i] == SEL_SAME) begin
					ch = in_ch;
				end else begin
					offset = sels[i] - 5'd2;
					ch     = offset[3:0];
				end
				dup = 1'b0;
				for (int j = 0; j < n; j++)
					if (used[j] == ch)
						dup = 1'b1;
				if (!dup) begin
					used[n]                     = ch;
					copies[n].out_status_byte   = {kind, ch};
					copies[n].out_data_one      = msg.data_one;
					copies[n].out_data_two      = three ? msg.data_two : 7'd0;
					copies[n].has_third_byte    = three;
					copies[n].send_destinations = route_cfg.destination_mask;
					copies[n].last_copy         = 1'b0;
					n++;
				end
			end
		end

		for (int k = 0; k < n; k++) begin
			copies[k].last_copy = (k == n - 1);
			pending_copies.push_back(copies[k]);
		end
		return n;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Every copy taken from the block is compared with the oldest one still owed.
	always @(posedge clk) begin : copy_checker
		mcr_out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_copies.size() == 0) begin
				error_count++;
				$display("%0t: unexpected copy, expected none, actual %h", $time, out_item);
			end else begin
				want = pending_copies.pop_front();
				check_field("out_status_byte", want.out_status_byte, out_item.out_status_byte);
				check_field("out_data_one", 8'(want.out_data_one),
					8'(out_item.out_data_one));
				check_field("out_data_two", 8'(want.out_data_two),
					8'(out_item.out_data_two));
				check_field("has_third_byte", 8'(want.has_third_byte),
					8'(out_item.has_third_byte));
				check_field("send_destinations", 8'(want.send_destinations),
					8'(out_item.send_destinations));
				check_field("last_copy", 8'(want.last_copy), 8'(out_item.last_copy));
			end
		end
	end

	// Offers one message and waits for it to be taken. Gaps are made by dropping valid
	// before the message, never after it, so that back-to-back messages keep valid high
	// and valid only ever gets one assignment per edge.
	task automatic send_message(input mcr_in_t msg, output int copies);
		while (!steady && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= msg;
		do
			@(posedge clk);
		while (!in_ready);
		copies = route_message(msg);
	endtask

	// Lets the block run empty: all owed copies out, then a margin for filtered messages.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_copies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drives one register write; the caller lowers the write enable after the last one.
	task automatic write_register(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Loads the whole register file. Only called while the block is idle.
	task automatic apply_settings(input mcr_cfg_t c);
		write_register(CFG_DEST_MASK, CFG_DATA_W'(c.destination_mask));
		write_register(CFG_CH_FIRST, CFG_DATA_W'(c.in_channel_first));
		write_register(CFG_CH_LAST, CFG_DATA_W'(c.in_channel_last));
		write_register(CFG_MSG_CLASS, CFG_DATA_W'(c.message_class));
		write_register(CFG_CC_WINDOW, CFG_DATA_W'(c.cc_window));
		write_register(CFG_FIRST_SEL, CFG_DATA_W'(c.first_output_select));
		write_register(CFG_SECOND_SEL, CFG_DATA_W'(c.second_output_select));
		write_register(CFG_THRU_SEL, CFG_DATA_W'(c.thru_output_select));
		cfg_write <= 1'b0;
		route_cfg = c;
	endtask

	// Random settings, leaning toward ones that let messages through so that most
	// phases produce plenty of copies; the full register ranges still appear.
	function automatic mcr_cfg_t pick_settings();
		mcr_cfg_t c;
		int       r;
		c.destination_mask = ($urandom_range(0, 11) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
		r = $urandom_range(0, 9);
		c.in_channel_first = (r < 3) ? 5'd0 : (r < 9) ? 5'($urandom_range(1, 16))
			: 5'($urandom_range(0, 31));
		r = $urandom_range(0, 9);
		c.in_channel_last = (r < 3) ? 5'd0 : (r < 9) ? 5'($urandom_range(1, 16))
			: 5'($urandom_range(0, 31));
		c.message_class = 2'($urandom_range(0, 3));
		c.cc_window     = 14'($urandom_range(0, 16383));
		r = $urandom_range(0, 9);
		c.first_output_select = (r < 2) ? SEL_OFF : (r < 4) ? SEL_SAME
			: (r < 9) ? 5'($urandom_range(2, 17)) : 5'($urandom_range(0, 31));
		r = $urandom_range(0, 9);
		c.second_output_select = (r < 2) ? SEL_OFF : (r < 4) ? SEL_SAME
			: (r < 9) ? 5'($urandom_range(2, 17)) : 5'($urandom_range(0, 31));
		r = $urandom_range(0, 9);
		c.thru_output_select = (r < 3) ? SEL_OFF : (r < 5) ? SEL_SAME
			: (r < 9) ? 5'($urandom_range(2, 17)) : 5'($urandom_range(0, 31));
		return c;
	endfunction

	// Mostly channel messages aimed at the accepted channel range and, for control
	// change, at the controller window; about a fifth are arbitrary status bytes.
	function automatic mcr_in_t pick_message();
		mcr_in_t    msg;
		logic [3:0] kind;
		logic [4:0] lo;
		logic [4:0] hi;
		logic [4:0] swap5;
		logic [6:0] cc_lo;
		logic [6:0] cc_hi;
		logic [3:0] ch;
		msg.data_one = 7'($urandom_range(0, 127));
		msg.data_two = 7'($urandom_range(0, 127));
		if ($urandom_range(0, 99) < 20) begin
			msg.status_byte = 8'($urandom_range(0, 255));
			return msg;
		end
		kind = ($urandom_range(0, 9) < 4) ? TYPE_CC : 4'($urandom_range(8, 14));
		lo   = route_cfg.in_channel_first;
		hi   = (route_cfg.in_channel_last == 5'd0) ? lo : route_cfg.in_channel_last;
		if (lo > hi) begin
			swap5 = lo;
			lo    = hi;
			hi    = swap5;
		end
		if (hi > 5'd16)
			hi = 5'd16;
		if (lo == 5'd0 || lo > hi)
			ch = 4'($urandom_range(0, 15));
		else
			ch = 4'($urandom_range(lo, hi) - 1);
		msg.status_byte = {kind, ch};
		if (kind == TYPE_CC && $urandom_range(0, 9) < 7) begin
			cc_lo = route_cfg.cc_window[6:0];
			cc_hi = route_cfg.cc_window[13:7];
			msg.data_one = 7'($urandom_range(cc_lo, cc_hi));
		end
		return msg;
	endfunction

	// Reset settings: channel 1 only, control change only, full controller window,
	// copies on channels 2 and 3 and no thru.
	task automatic test_default_settings();
		int n;
		send_message({TYPE_CC, 4'h0, 7'd0, 7'd127}, n);
		send_message({TYPE_CC, 4'h0, 7'd127, 7'd0}, n);
		send_message({TYPE_NOTE_ON, 4'h0, 7'd60, 7'd100}, n);
		send_message({TYPE_CC, 4'hF, 7'd1, 7'd1}, n);
		settle();
	endtask

	// Every status nibble once, including system and data-byte nibbles, with all
	// channel messages allowed. The thru copy on channel 0 and the second copy on
	// channel 15 collide with the same-channel copy on the extreme channels.
	task automatic test_message_types();
		mcr_cfg_t c;
		int       n;
		c = '{destination_mask: 4'd15, in_channel_first: 5'd0, in_channel_last: 5'd0,
			message_class: 2'd2, cc_window: 14'd16256, first_output_select: SEL_SAME,
			second_output_select: 5'd17, thru_output_select: 5'd2};
		apply_settings(c);
		for (int t = 0; t < 16; t++) begin
			if (t % 2 == 0)
				send_message({4'(t), 4'h0, 7'd0, 7'd127}, n);
			else
				send_message({4'(t), 4'hF, 7'd127, 7'd0}, n);
		end
		settle();
	endtask

	// Routing switched off, reversed channel and controller bounds, both unused class
	// codes, selectors past seventeen that wrap, and input bounds above sixteen.
	task automatic test_special_settings();
		mcr_cfg_t c;
		int       n;
		c = '{destination_mask: 4'd0, in_channel_first: 5'd0, in_channel_last: 5'd0,
			message_class: 2'd2, cc_window: 14'd16256, first_output_select: SEL_SAME,
			second_output_select: SEL_OFF, thru_output_select: SEL_OFF};
		apply_settings(c);
		send_message({TYPE_CC, 4'h3, 7'd10, 7'd20}, n);
		settle();

		// Channels 4..9 and controllers 20..100, both given high bound first.
		c = '{destination_mask: 4'd6, in_channel_first: 5'd9, in_channel_last: 5'd4,
			message_class: 2'd3, cc_window: {7'd20, 7'd100}, first_output_select: 5'd18,
			second_output_select: 5'd31, thru_output_select: SEL_SAME};
		apply_settings(c);
		send_message({TYPE_CC, 4'h3, 7'd20, 7'd5}, n);
		send_message({TYPE_CC, 4'h8, 7'd100, 7'd127}, n);
		send_message({TYPE_CC, 4'h9, 7'd50, 7'd1}, n);
		send_message({TYPE_CC, 4'h4, 7'd19, 7'd1}, n);
		send_message({TYPE_PITCHBEND, 4'h5, 7'd64, 7'd64}, n);
		settle();

		// Bounds 31 and 16, reversed: only channel 16 gets through.
		c.in_channel_first = 5'd31;
		c.in_channel_last  = 5'd16;
		apply_settings(c);
		send_message({TYPE_PROGRAM, 4'hF, 7'd5, 7'd99}, n);
		send_message({TYPE_PROGRAM, 4'hE, 7'd5, 7'd99}, n);
		settle();
	endtask

	// Random settings, each run with a fixed number of random messages.
	// The first two phases use the largest and smallest values that still route, and
	// one phase runs with no gaps or stalls at all.
	task automatic test_random_routing();
		mcr_cfg_t c;
		int       n;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				c = '{destination_mask: 4'd15, in_channel_first: 5'd16, in_channel_last: 5'd16,
					message_class: 2'd3, cc_window: 14'h3FFF, first_output_select: 5'd17,
					second_output_select: 5'd17, thru_output_select: 5'd17};
			else if (phase == 1)
				c = '{destination_mask: 4'd1, in_channel_first: 5'd0, in_channel_last: 5'd0,
					message_class: CLASS_CC_ONLY, cc_window: 14'd0,
					first_output_select: SEL_SAME, second_output_select: SEL_OFF,
					thru_output_select: SEL_OFF};
			else
				c = pick_settings();
			apply_settings(c);
			steady = (phase == 4);
			for (int m = 0; m < MESSAGES_PER_PHASE; m++)
				send_message(pick_message(), n);
			settle();
			steady = 1'b0;
		end
	endtask

	initial begin
		route_cfg = '{destination_mask: RST_DEST_MASK, in_channel_first: RST_CH_FIRST,
			in_channel_last: RST_CH_LAST, message_class: RST_MSG_CLASS,
			cc_window: RST_CC_WINDOW, first_output_select: RST_FIRST_SEL,
			second_output_select: RST_SECOND_SEL, thru_output_select: RST_THRU_SEL};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_message_types();
		test_special_settings();
		test_random_routing();
		settle();

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/mcr_pkg.sv
rtl/core/mcr_front.sv
rtl/core/mcr_queue.sv
rtl/core/mcr_back.sv
rtl/core/midi_channel_router.sv
sim/tb_top.sv
